FILE: src/heater_fan_mode_controller_macros.svh
// Assertion macros shared by the heater fan mode controller checkers.
// No dependencies; include by bare file name inside a module body.
`ifndef HEATER_FAN_MODE_CONTROLLER_MACROS_SVH
`define HEATER_FAN_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFMC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("heater_fan_mode_controller: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HFMC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("heater_fan_mode_controller: next-cycle check failed");

`endif

FILE: src/hfmc_pkg.sv
// Shared types and constants of the heater fan mode controller.
// No dependencies.
package hfmc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_FAN_DUTY_COOL    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAN_DUTY_WARM    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HEATER_FULL_DUTY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SWING_STEPS      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_HOUR   = 3'd4;

  // Key flag bit positions.
  localparam int unsigned KEY_POWER = 0;
  localparam int unsigned KEY_SWING = 1;
  localparam int unsigned KEY_MODE  = 2;
  localparam int unsigned KEY_TIMER = 3;

  // LED bit positions inside held_leds.
  localparam int unsigned LED_MODE  = 0;
  localparam int unsigned LED_VERT  = 1;
  localparam int unsigned LED_HORIZ = 2;
  localparam int unsigned LED_TIMER = 3;

  // Configuration reset values.
  localparam logic [7:0]  FAN_DUTY_COOL_RST    = 8'd50;
  localparam logic [7:0]  FAN_DUTY_WARM_RST    = 8'd80;
  localparam logic [7:0]  HEATER_FULL_DUTY_RST = 8'd100;
  localparam logic [15:0] SWING_STEPS_RST      = 16'd200;
  localparam logic [23:0] TICKS_PER_HOUR_RST   = 24'd3600000;

  typedef enum logic [1:0] {
    AIR_OFF  = 2'd0,
    AIR_COOL = 2'd1,
    AIR_WARM = 2'd2
  } air_mode_e;

  typedef struct packed {
    logic [7:0]  fan_duty_cool;
    logic [7:0]  fan_duty_warm;
    logic [7:0]  heater_full_duty;
    logic [15:0] swing_steps;
    logic [23:0] ticks_per_hour;
  } cfg_t;

  typedef struct packed {
    logic        power;
    logic        swing_en;
    air_mode_e   air_mode;
    logic [3:0]  shutoff_hours;
    logic [3:0]  prev_keys;
    logic [1:0]  phase_idx;
    logic        swing_dir;
    logic [15:0] step_cnt;
    logic [7:0]  ramp_cnt;
    logic [23:0] tick_cnt;
    logic [3:0]  hour_cnt;
    logic [3:0]  held_phase;
    logic [3:0]  held_leds;
  } state_t;

  typedef struct packed {
    logic [7:0] fan_duty;
    logic [7:0] heater_duty;
    logic [3:0] motor_phase;
    logic [3:0] leds;
    logic       powered;
    logic       safe;
  } result_t;

endpackage

FILE: src/hfmc_tick.sv
// Next-state and result logic for one control tick.
// Depends on hfmc_pkg.
module hfmc_tick (
  input  hfmc_pkg::cfg_t    cfg_i,
  input  hfmc_pkg::state_t  state_i,
  input  logic [3:0]        key_flags_i,
  input  logic              tilt_switch_i,
  output hfmc_pkg::state_t  state_o,
  output hfmc_pkg::result_t result_o
);
  import hfmc_pkg::*;

  state_t     s;
  logic [7:0] fan;
  logic [7:0] heat;

  always_comb begin
    s    = state_i;
    fan  = 8'd0;
    heat = 8'd0;

    if (tilt_switch_i) begin
      s.power = 1'b0;
    end else begin
      // Key edges, highest priority only.
      if (key_flags_i == 4'd0) begin
        s.prev_keys = 4'd0;
      end else if (key_flags_i != s.prev_keys) begin
        s.prev_keys = key_flags_i;
        if (key_flags_i[KEY_POWER]) begin
          s.power = ~s.power;
          if (!s.power) begin
            s.swing_en      = 1'b0;
            s.air_mode      = AIR_OFF;
            s.shutoff_hours = 4'd0;
          end
        end else if (key_flags_i[KEY_SWING] && s.power) begin
          s.swing_en = ~s.swing_en;
        end else if (key_flags_i[KEY_MODE] && s.power) begin
          s.air_mode = (s.air_mode == AIR_COOL) ? AIR_WARM : AIR_COOL;
        end else if (key_flags_i[KEY_TIMER] && s.power) begin
          s.shutoff_hours = s.shutoff_hours + 4'd1;
        end
      end

      s.held_leds = 4'd0;
      if (s.power) begin
        s.held_leds[LED_MODE]  = (s.air_mode == AIR_COOL) || (s.air_mode == AIR_WARM);
        s.held_leds[LED_VERT]  = s.swing_en && !s.swing_dir;
        s.held_leds[LED_HORIZ] = s.swing_en && s.swing_dir;
        s.held_leds[LED_TIMER] = (s.shutoff_hours != 4'd0);
      end

      // Swing stepper: drive current phase, then advance.
      if (s.swing_en && s.power) begin
        s.held_phase = 4'b0001 << s.phase_idx;
        s.phase_idx  = s.swing_dir ? (s.phase_idx - 2'd1) : (s.phase_idx + 2'd1);
        s.step_cnt   = s.step_cnt + 16'd1;
        if (s.step_cnt >= cfg_i.swing_steps) begin
          s.step_cnt  = 16'd0;
          s.swing_dir = ~s.swing_dir;
        end
      end else begin
        s.held_phase = 4'd0;
      end

      if (s.power && (s.air_mode == AIR_COOL)) begin
        fan = cfg_i.fan_duty_cool;
      end else if (s.power && (s.air_mode == AIR_WARM)) begin
        fan = cfg_i.fan_duty_warm;
      end

      // Soft heater ramp.
      if (s.power && (s.air_mode == AIR_WARM)) begin
        if (s.ramp_cnt < cfg_i.heater_full_duty) begin
          heat       = s.ramp_cnt;
          s.ramp_cnt = s.ramp_cnt + 8'd1;
        end else begin
          heat = cfg_i.heater_full_duty;
        end
      end else begin
        s.ramp_cnt = 8'd0;
      end

      // Shutoff countdown.
      if ((s.shutoff_hours != 4'd0) && s.power) begin
        s.tick_cnt = s.tick_cnt + 24'd1;
        if (s.tick_cnt >= cfg_i.ticks_per_hour) begin
          s.tick_cnt = 24'd0;
          s.hour_cnt = s.hour_cnt + 4'd1;
          if (s.hour_cnt >= s.shutoff_hours) begin
            s.power         = 1'b0;
            s.shutoff_hours = 4'd0;
            s.hour_cnt      = 4'd0;
          end
        end
      end else begin
        s.hour_cnt = 4'd0;
        s.tick_cnt = 24'd0;
      end
    end
  end

  assign state_o              = s;
  assign result_o.fan_duty    = fan;
  assign result_o.heater_duty = heat;
  assign result_o.motor_phase = s.held_phase;
  assign result_o.leds        = s.held_leds;
  assign result_o.powered     = s.power;
  assign result_o.safe        = ~tilt_switch_i;

endmodule

FILE: src/heater_fan_mode_controller.sv
// Top level of the heater fan mode controller: handshake, state and result registers.
// Depends on hfmc_pkg and hfmc_tick.
//
// Usage:
//   Each input transfer (in_valid_i high, in_stall_o low at a rising edge) is one
//   control tick carrying the touch-key flags and the tilt switch level.
//   Each tick yields exactly one result transfer (out_valid_o high, out_stall_i low)
//   with fan and heater duty, the swing coil pattern (one-hot or zero), four LEDs, the power
//   state and the safe flag.
//   The result reaches the output register in the cycle after the input transfer.
//   Throughput: one tick per cycle unless stalled; the tick logic is a single
//   combinational pass from the state registers into the result register.
//   When the receiver stalls, the result register holds and in_stall_o rises so no
//   new tick is taken; a result leaving in the same cycle frees the slot at once.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   clock edge; indexes beyond the register list are ignored. Write only while idle.
//   Reset clears all tick state (power off, mode off, counters zero), restores the
//   register defaults and empties the output register.
module heater_fan_mode_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [hfmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hfmc_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [3:0]                     key_flags_i,
  input  logic                           tilt_switch_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     fan_duty_o,
  output logic [7:0]                     heater_duty_o,
  output logic [3:0]                     motor_phase_o,
  output logic                           mode_led_o,
  output logic                           vertical_swing_led_o,
  output logic                           horizontal_swing_led_o,
  output logic                           timer_led_o,
  output logic                           powered_o,
  output logic                           safe_o
);
  import hfmc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_xfer;

  // Take a new tick unless a finished result is stuck at a stalled receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fan_duty_cool    <= FAN_DUTY_COOL_RST;
      cfg_q.fan_duty_warm    <= FAN_DUTY_WARM_RST;
      cfg_q.heater_full_duty <= HEATER_FULL_DUTY_RST;
      cfg_q.swing_steps      <= SWING_STEPS_RST;
      cfg_q.ticks_per_hour   <= TICKS_PER_HOUR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FAN_DUTY_COOL:    cfg_q.fan_duty_cool    <= cfg_data_i[7:0];
        REG_FAN_DUTY_WARM:    cfg_q.fan_duty_warm    <= cfg_data_i[7:0];
        REG_HEATER_FULL_DUTY: cfg_q.heater_full_duty <= cfg_data_i[7:0];
        REG_SWING_STEPS:      cfg_q.swing_steps      <= cfg_data_i[15:0];
        REG_TICKS_PER_HOUR:   cfg_q.ticks_per_hour   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // One tick of key handling, stepper, duties and shutoff timer.
  hfmc_tick u_tick (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .key_flags_i   (key_flags_i),
    .tilt_switch_i (tilt_switch_i),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // Advance the controller state on each input transfer only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Output register: fill on input transfer, drop after output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload holds while stalled since in_xfer is low then.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign fan_duty_o             = res_q.fan_duty;
  assign heater_duty_o          = res_q.heater_duty;
  assign motor_phase_o          = res_q.motor_phase;
  assign mode_led_o             = res_q.leds[LED_MODE];
  assign vertical_swing_led_o   = res_q.leds[LED_VERT];
  assign horizontal_swing_led_o = res_q.leds[LED_HORIZ];
  assign timer_led_o            = res_q.leds[LED_TIMER];
  assign powered_o              = res_q.powered;
  assign safe_o                 = res_q.safe;

endmodule

FILE: src/hfmc_checker.sv
// Port-level checks of the heater fan mode controller, bound to the top level.
// Depends on heater_fan_mode_controller_macros.svh.
module hfmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] fan_duty_o,
  input logic [7:0] heater_duty_o,
  input logic [3:0] motor_phase_o,
  input logic       mode_led_o,
  input logic       vertical_swing_led_o,
  input logic       horizontal_swing_led_o,
  input logic       timer_led_o,
  input logic       powered_o,
  input logic       safe_o
);
`include "heater_fan_mode_controller_macros.svh"

  // A stalled result stays put.
  `HFMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(fan_duty_o) && $stable(heater_duty_o) && $stable(motor_phase_o) && $stable(powered_o))

  // A tilt fault forces power off and zero duties.
  `HFMC_ASSERT_IMP(a_tilt_off, clk_i, rst_ni, out_valid_o && !safe_o, !powered_o && (fan_duty_o == 8'd0) && (heater_duty_o == 8'd0))

  // The coil pattern is one-hot or idle.
  `HFMC_ASSERT_IMP(a_phase_onehot, clk_i, rst_ni, out_valid_o, $onehot0(motor_phase_o))

  // Only one swing direction LED at a time.
  `HFMC_ASSERT_IMP(a_swing_leds, clk_i, rst_ni, out_valid_o, !(vertical_swing_led_o && horizontal_swing_led_o))

  // Fresh LEDs on an upright tick without power at its end mean the shutoff timer fired.
  `HFMC_ASSERT_IMP(a_mode_power, clk_i, rst_ni, out_valid_o && safe_o && !powered_o && mode_led_o, timer_led_o)

endmodule

bind heater_fan_mode_controller hfmc_checker u_hfmc_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .fan_duty_o             (fan_duty_o),
  .heater_duty_o          (heater_duty_o),
  .motor_phase_o          (motor_phase_o),
  .mode_led_o             (mode_led_o),
  .vertical_swing_led_o   (vertical_swing_led_o),
  .horizontal_swing_led_o (horizontal_swing_led_o),
  .timer_led_o            (timer_led_o),
  .powered_o              (powered_o),
  .safe_o                 (safe_o)
);

FILE: tb/sv/tb_heater_fan_mode_controller.sv
// Self-checking testbench of the heater fan mode controller: random key and tilt ticks
// with idling on both channels. Each result is checked against a tick predictor.
// Depends on hfmc_pkg and heater_fan_mode_controller.
module tb_heater_fan_mode_controller;
  import hfmc_pkg::*;

  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned TILT_PCT   = 4;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LAST_UNUSED  = 3'd7;

  localparam logic [3:0] PRESS_NONE  = 4'h0;
  localparam logic [3:0] PRESS_POWER = 4'(1 << KEY_POWER);
  localparam logic [3:0] PRESS_SWING = 4'(1 << KEY_SWING);
  localparam logic [3:0] PRESS_MODE  = 4'(1 << KEY_MODE);
  localparam logic [3:0] PRESS_TIMER = 4'(1 << KEY_TIMER);
  localparam logic [3:0] PRESS_ALL   = PRESS_POWER | PRESS_SWING | PRESS_MODE | PRESS_TIMER;

  // Tracks the controller state per tick and holds the results still owed.
  class fan_tick_board;
    cfg_t        regs;
    bit          power, swing_en, swing_dir;
    air_mode_e   mode;
    logic [3:0]  hours, prev_keys, hour_cnt, held_phase, held_leds;
    logic [1:0]  phase_idx;
    logic [15:0] step_cnt;
    logic [7:0]  ramp_cnt;
    logic [23:0] tick_cnt;
    result_t     owed_results[$];
    int unsigned errors, results_seen;

    function new();
      regs.fan_duty_cool    = FAN_DUTY_COOL_RST;
      regs.fan_duty_warm    = FAN_DUTY_WARM_RST;
      regs.heater_full_duty = HEATER_FULL_DUTY_RST;
      regs.swing_steps      = SWING_STEPS_RST;
      regs.ticks_per_hour   = TICKS_PER_HOUR_RST;
      power = 1'b0; swing_en = 1'b0; swing_dir = 1'b0; mode = AIR_OFF;
      hours = '0; prev_keys = '0; hour_cnt = '0; held_phase = '0; held_leds = '0;
      phase_idx = '0; step_cnt = '0; ramp_cnt = '0; tick_cnt = '0;
      errors = 0; results_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_FAN_DUTY_COOL:    regs.fan_duty_cool    = data[7:0];
        REG_FAN_DUTY_WARM:    regs.fan_duty_warm    = data[7:0];
        REG_HEATER_FULL_DUTY: regs.heater_full_duty = data[7:0];
        REG_SWING_STEPS:      regs.swing_steps      = data[15:0];
        REG_TICKS_PER_HOUR:   regs.ticks_per_hour   = data[23:0];
        default: ;
      endcase
    endfunction

    // Advance one control tick and queue the result it owes.
    function void note_tick(logic [3:0] keys, logic tilt);
      result_t r;
      r = '0;
      r.safe = ~tilt;
      if (tilt) begin
        power = 1'b0;
      end else begin
        // Act on a new nonzero pattern only, highest priority key wins.
        if (keys == PRESS_NONE) begin
          prev_keys = '0;
        end else if (keys != prev_keys) begin
          prev_keys = keys;
          if (keys[KEY_POWER]) begin
            power = ~power;
            if (!power) begin
              swing_en = 1'b0;
              mode     = AIR_OFF;
              hours    = '0;
            end
          end else if (keys[KEY_SWING] && power) begin
            swing_en = ~swing_en;
          end else if (keys[KEY_MODE] && power) begin
            mode = (mode == AIR_COOL) ? AIR_WARM : AIR_COOL;
          end else if (keys[KEY_TIMER] && power) begin
            hours = hours + 4'd1;
          end
        end

        held_leds = '0;
        if (power) begin
          held_leds[LED_MODE] = (mode == AIR_COOL || mode == AIR_WARM);
          if (swing_en) held_leds[swing_dir ? LED_HORIZ : LED_VERT] = 1'b1;
          held_leds[LED_TIMER] = (hours != '0);
        end

        if (swing_en && power) begin
          held_phase = 4'b0001 << phase_idx;
          phase_idx  = swing_dir ? phase_idx - 2'd1 : phase_idx + 2'd1;
          step_cnt   = step_cnt + 16'd1;
          if (step_cnt >= regs.swing_steps) begin
            step_cnt  = '0;
            swing_dir = ~swing_dir;
          end
        end else begin
          held_phase = '0;
        end

        if (power && mode == AIR_COOL) r.fan_duty = regs.fan_duty_cool;
        else if (power && mode == AIR_WARM) r.fan_duty = regs.fan_duty_warm;

        // Soft start of the heater: duty follows the ramp count up to full duty.
        if (power && mode == AIR_WARM) begin
          if (ramp_cnt < regs.heater_full_duty) begin
            r.heater_duty = ramp_cnt;
            ramp_cnt      = ramp_cnt + 8'd1;
          end else begin
            r.heater_duty = regs.heater_full_duty;
          end
        end else begin
          ramp_cnt = '0;
        end

        if (hours != '0 && power) begin
          tick_cnt = tick_cnt + 24'd1;
          if (tick_cnt >= regs.ticks_per_hour) begin
            tick_cnt = '0;
            hour_cnt = hour_cnt + 4'd1;
            if (hour_cnt >= hours) begin
              power    = 1'b0;
              hours    = '0;
              hour_cnt = '0;
            end
          end
        end else begin
          hour_cnt = '0;
          tick_cnt = '0;
        end
      end
      r.motor_phase = held_phase;
      r.leds        = held_leds;
      r.powered     = power;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: %s mismatch, expected %0h, got %0h",
                   results_seen, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d arrived with no tick outstanding", results_seen);
        return;
      end
      want = owed_results.pop_front();
      compare_field("fan_duty", want.fan_duty, got.fan_duty);
      compare_field("heater_duty", want.heater_duty, got.heater_duty);
      compare_field("motor_phase", 8'(want.motor_phase), 8'(got.motor_phase));
      compare_field("mode_led", 8'(want.leds[LED_MODE]), 8'(got.leds[LED_MODE]));
      compare_field("vertical_swing_led", 8'(want.leds[LED_VERT]), 8'(got.leds[LED_VERT]));
      compare_field("horizontal_swing_led", 8'(want.leds[LED_HORIZ]),
                    8'(got.leds[LED_HORIZ]));
      compare_field("timer_led", 8'(want.leds[LED_TIMER]), 8'(got.leds[LED_TIMER]));
      compare_field("powered", 8'(want.powered), 8'(got.powered));
      compare_field("safe", 8'(want.safe), 8'(got.safe));
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic [3:0]          key_flags_i   = '0;
  logic                tilt_switch_i = 1'b0;
  logic                out_stall_i   = 1'b0;
  logic                in_stall_o, out_valid_o;
  logic [7:0]          fan_duty_o, heater_duty_o;
  logic [3:0]          motor_phase_o;
  logic                mode_led_o, vertical_swing_led_o, horizontal_swing_led_o;
  logic                timer_led_o, powered_o, safe_o;

  result_t       out_word;
  fan_tick_board board = new();

  // Idle and stall controls; the stall side is read by its own process.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          pressure_on    = 1'b0;
  int unsigned stall_cycle    = 0;
  logic [3:0]  last_keys      = '0;

  heater_fan_mode_controller uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .key_flags_i            (key_flags_i),
    .tilt_switch_i          (tilt_switch_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .fan_duty_o             (fan_duty_o),
    .heater_duty_o          (heater_duty_o),
    .motor_phase_o          (motor_phase_o),
    .mode_led_o             (mode_led_o),
    .vertical_swing_led_o   (vertical_swing_led_o),
    .horizontal_swing_led_o (horizontal_swing_led_o),
    .timer_led_o            (timer_led_o),
    .powered_o              (powered_o),
    .safe_o                 (safe_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  assign out_word = {fan_duty_o, heater_duty_o, motor_phase_o, timer_led_o,
                     horizontal_swing_led_o, vertical_swing_led_o, mode_led_o,
                     powered_o, safe_o};

  // Sample both channels on the pre-edge values; every driver uses nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_tick(key_flags_i, tilt_switch_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_word);
  end

  // Receiver stall. Under pressure, hold off for long stretches counted here so the
  // result slot fills and the block must stall its input.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (pressure_on && (stall_cycle % 150) < 90) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Mostly press-and-release sequences; some held patterns and chords.
  function automatic logic [3:0] pick_keys();
    int unsigned r;
    logic [3:0]  keys;
    r = $urandom_range(99);
    if (r < 50) begin
      keys = PRESS_NONE;
    end else if (r < 85) begin
      r = $urandom_range(9);
      if (r == 0) keys = PRESS_POWER;
      else if (r < 4) keys = PRESS_SWING;
      else if (r < 7) keys = PRESS_MODE;
      else keys = PRESS_TIMER;
    end else if (r < 92) begin
      keys = last_keys;
    end else begin
      keys = 4'($urandom_range(15));
    end
    last_keys = keys;
    return keys;
  endfunction

  // Offer one tick, with a random gap first, and hold it until the transfer.
  task automatic send_tick(input logic [3:0] keys, input logic tilt);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i    <= 1'b1;
    key_flags_i   <= keys;
    tilt_switch_i <= tilt;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Write every register, with junk in the unused upper bits, plus one stray index.
  task automatic program_regs(input logic [7:0] cool, warm, heat, input logic [15:0] steps,
                              input logic [23:0] tph);
    write_reg(REG_FAN_DUTY_COOL, {16'($urandom), cool});
    write_reg(REG_FAN_DUTY_WARM, {16'($urandom), warm});
    write_reg(REG_HEATER_FULL_DUTY, {16'($urandom), heat});
    write_reg(REG_SWING_STEPS, {8'($urandom), steps});
    write_reg(REG_TICKS_PER_HOUR, tph);
    write_reg(CfgIdxW'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 24'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Wait out every owed result, then idle for a margin.
  task automatic drain();
    while (board.owed() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] cool, warm, heat, input logic [15:0] steps,
                           input logic [23:0] tph, input int unsigned src_pct, sink_pct,
                           input bit press, input int unsigned n_ticks);
    program_regs(cool, warm, heat, steps, tph);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    pressure_on    <= press;
    repeat (n_ticks) send_tick(pick_keys(), $urandom_range(99) < TILT_PCT);
    in_valid_i  <= 1'b0;
    pressure_on <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk on the reset register values: keys while off, held keys,
    // every key, chords, a tilt fault that keeps mode and hours, power toggling.
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_SWING, 1'b0);
    send_tick(PRESS_MODE, 1'b0);
    send_tick(PRESS_TIMER, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_POWER, 1'b0);
    send_tick(PRESS_POWER, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_MODE, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_MODE, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_SWING, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_TIMER, 1'b0);
    send_tick(PRESS_SWING | PRESS_MODE | PRESS_TIMER, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_MODE | PRESS_TIMER, 1'b0);
    send_tick(PRESS_ALL, 1'b1);
    send_tick(PRESS_NONE, 1'b1);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_POWER, 1'b0);
    send_tick(PRESS_POWER | PRESS_TIMER, 1'b0);
    send_tick(PRESS_NONE, 1'b0);
    send_tick(PRESS_ALL, 1'b0);
    in_valid_i <= 1'b0;
    drain();

    // Register extremes, zero counts and random settings, across the idle styles.
    run_phase(8'd0, 8'd255, 8'd255, 16'd1, 24'd1, 0, 0, 1'b0, 220);
    run_phase(8'd255, 8'd0, 8'd0, 16'hFFFF, 24'hFFFFFF, 84, 0, 1'b0, 220);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(40)),
              16'($urandom_range(1, 10)), 24'($urandom_range(1, 30)), 0, 84, 1'b0, 220);
    run_phase(8'($urandom), 8'($urandom), 8'd20, 16'd0, 24'd0, 16, 16, 1'b0, 220);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(60)),
              16'($urandom_range(1, 6)), 24'($urandom_range(1, 12)), 0, 0, 1'b1, 220);
    run_phase(8'($urandom), 8'($urandom), 8'd255, 16'd3, 24'd3, 16, 16, 1'b0, 220);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(30)),
              16'($urandom_range(1, 20)), 24'($urandom_range(1, 8)), 0, 0, 1'b0, 220);

    repeat (4) @(posedge clk_i);
    if (board.errors == 0 && board.owed() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Timeout far beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/hfmc_pkg.sv
src/hfmc_tick.sv
src/heater_fan_mode_controller.sv
src/hfmc_checker.sv
tb/sv/tb_heater_fan_mode_controller.sv
